// ----- rtl/ais_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the ASCII integer scanner.
// No dependencies; every other file of the block but ais_if imports this package.
package ais_pkg;

   localparam int DIGIT_W     = 6;
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_LVL_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [DIGIT_W-1:0] DIGIT_NONE = 6'd63;
   localparam logic [DIGIT_W-1:0] RADIX_MAX  = 6'd36;
   localparam logic [DIGIT_W-1:0] RADIX_ONE  = 6'd1;
   localparam logic [DIGIT_W-1:0] RADIX_AUTO = 6'd0;
   localparam logic [DIGIT_W-1:0] RADIX_OCT  = 6'd8;
   localparam logic [DIGIT_W-1:0] RADIX_DEC  = 6'd10;
   localparam logic [DIGIT_W-1:0] RADIX_HEX  = 6'd16;

   // configuration register indexes
   localparam logic [1:0] CSR_RADIX     = 2'd0;
   localparam logic [1:0] CSR_PREFIX_OK = 2'd1;
   localparam logic [1:0] CSR_LIMIT     = 2'd2;

   typedef enum logic [2:0] {
      ST_OK          = 3'd0,
      ST_RANGE       = 3'd1,
      ST_NO_DIGITS   = 3'd2,
      ST_BAD_RADIX   = 3'd3,
      ST_BARE_PREFIX = 3'd4
   } ais_status_type;

   typedef enum logic [2:0] {
      PH_WS     = 3'd0,
      PH_SIGNED = 3'd1,
      PH_ZERO   = 3'd2,
      PH_PREFIX = 3'd3,
      PH_DIGITS = 3'd4,
      PH_OVER   = 3'd5
   } ais_phase_type;

   typedef enum logic [2:0] {
      EV_NONE        = 3'd0,
      EV_BAD_RADIX   = 3'd1,
      EV_NO_DIGITS   = 3'd2,
      EV_BARE_PREFIX = 3'd3,
      EV_FINISH      = 3'd4
   } ais_event_type;

   // pre-decoded character
   typedef struct packed {
      logic [DIGIT_W-1:0] digit;    // 0..35, DIGIT_NONE otherwise
      logic               is_space;
      logic               is_plus;
      logic               is_minus;
      logic               is_zero;
      logic               is_x;
   } ais_class_type;

   typedef struct packed {
      logic [5:0]  radix;
      logic        prefix_ok;
      logic [63:0] limit;
   } ais_cfg_type;

endpackage

// ----- rtl/ais_if.sv -----
`timescale 1ns / 1ps
// Valid/ready channel interfaces for scanner requests and responses.
// Standalone; no package needed.
interface ais_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       at_end;

   modport source (output valid, char_code, at_end, input ready);
   modport sink   (input valid, char_code, at_end, output ready);
endinterface

interface ais_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] value;
   logic [15:0] used_count;
   logic [2:0]  status;

   modport source (output valid, value, used_count, status, input ready);
   modport sink   (input valid, value, used_count, status, output ready);
endinterface

// ----- rtl/ais_front.sv -----
`timescale 1ns / 1ps
// Front end: takes request items and decodes each character into a class word.
// Depends on ais_pkg and ais_req_if.
module ais_front
   import ais_pkg::*;
(
   ais_req_if.sink         req_ch,
   input  logic            q_full,
   output logic            push,
   output ais_class_type   push_item
);

   logic [7:0] ch;
   logic       live;

   assign ch           = req_ch.char_code;
   assign live         = !req_ch.at_end;
   assign req_ch.ready = !q_full;
   assign push         = req_ch.valid && !q_full;

   always_comb begin
      push_item.digit = DIGIT_NONE;
      if (live) begin
         if (ch >= 8'h30 && ch <= 8'h39)
            push_item.digit = DIGIT_W'(ch - 8'h30);
         else if (ch >= 8'h61 && ch <= 8'h7a)
            push_item.digit = DIGIT_W'(ch - 8'h57);
         else if (ch >= 8'h41 && ch <= 8'h5a)
            push_item.digit = DIGIT_W'(ch - 8'h37);
      end
      push_item.is_space = live && (ch == 8'h20 || (ch >= 8'h09 && ch <= 8'h0d));
      push_item.is_plus  = live && ch == 8'h2b;
      push_item.is_minus = live && ch == 8'h2d;
      push_item.is_zero  = live && ch == 8'h30;
      push_item.is_x     = live && (ch | 8'h20) == 8'h78;
   end

endmodule

// ----- rtl/ais_queue.sv -----
`timescale 1ns / 1ps
// Two-entry queue of decoded characters between front and back end.
// Depends on ais_pkg.
module ais_queue
   import ais_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ais_class_type          push_item,
   input  logic                   pop,
   output logic                   head_valid,
   output ais_class_type          head_item,
   output logic                   full,
   output logic [QUEUE_LVL_W-1:0] level
);

   ais_class_type            slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_LVL_W-1:0]   level_ff, level_in;

   assign head_valid = level_ff != '0;
   assign head_item  = slot_ff[rd_ptr_ff];
   assign full       = level_ff == QUEUE_LVL_W'(QUEUE_DEPTH);
   assign level      = level_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop)
         level_in = level_ff + 1'b1;
      else if (pop && !push)
         level_in = level_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         slot_ff[wr_ptr_ff] <= push_item;
   end

endmodule

// ----- rtl/ais_back.sv -----
`timescale 1ns / 1ps
// Back end: scan sequencer with multiply-add accumulator, clamp and output register.
// Depends on ais_pkg and ais_rsp_if.
module ais_back
   import ais_pkg::*;
#(
   parameter int VALUE_BITS = 64,
   parameter int COUNT_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  ais_cfg_type   cfg,
   input  logic          q_valid,
   input  ais_class_type q_item,
   output logic          q_pop,
   ais_rsp_if.source     rsp_ch
);

   localparam int          PROD_W     = VALUE_BITS + DIGIT_W;
   localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_BITS);

   ais_phase_type           phase_ff, phase_in;
   logic                    neg_ff, neg_in;
   logic [DIGIT_W-1:0]      base_ff, base_in;
   logic [VALUE_BITS-1:0]   acc_ff, acc_in;
   logic [COUNT_BITS-1:0]   cons_ff, cons_in;
   logic [COUNT_BITS-1:0]   cons_bump;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [63:0]             value_ff, value_in;
   logic [15:0]             count_ff, count_in;
   ais_status_type          status_ff, status_in;

   logic                    fire;
   logic                    bad_radix;
   ais_event_type           evt;

   assign fire      = q_valid && (!rsp_valid_ff || rsp_ch.ready);
   assign q_pop     = fire;
   assign bad_radix = cfg.radix > RADIX_MAX || cfg.radix == RADIX_ONE;
   assign cons_bump = (cons_ff == '1) ? cons_ff : cons_ff + 1'b1;

   // next state of the scan
   always_comb begin
      logic [DIGIT_W-1:0]    b;
      logic                  do_signed;
      logic                  tail;
      logic                  tail_mul;
      logic [VALUE_BITS-1:0] tail_acc;
      logic [PROD_W-1:0]     prod;

      phase_in  = phase_ff;
      neg_in    = neg_ff;
      base_in   = base_ff;
      acc_in    = acc_ff;
      cons_in   = cons_ff;
      evt       = EV_NONE;
      b         = base_ff;
      do_signed = 1'b0;
      tail      = 1'b0;
      tail_mul  = 1'b0;
      tail_acc  = acc_ff;
      prod      = '0;

      if (fire) begin
         case (phase_ff)
            PH_WS: begin
               if (bad_radix) begin
                  evt = EV_BAD_RADIX;
               end else begin
                  base_in = cfg.radix;
                  if (q_item.is_space) begin
                     cons_in = cons_bump;
                  end else if (q_item.is_plus || q_item.is_minus) begin
                     neg_in   = q_item.is_minus;
                     cons_in  = cons_bump;
                     phase_in = PH_SIGNED;
                  end else begin
                     do_signed = 1'b1;
                     b         = cfg.radix;
                  end
               end
            end
            PH_SIGNED: do_signed = 1'b1;
            PH_ZERO: begin
               if (q_item.is_x) begin
                  cons_in  = cons_bump;
                  phase_in = PH_PREFIX;
               end else begin
                  b        = (base_ff == RADIX_AUTO) ? RADIX_OCT : base_ff;
                  base_in  = b;
                  tail     = 1'b1;
                  tail_mul = 1'b1;
                  tail_acc = '0;
                  phase_in = PH_DIGITS;
               end
            end
            PH_PREFIX: begin
               if (q_item.digit >= RADIX_HEX) begin
                  evt = EV_BARE_PREFIX;
               end else begin
                  b        = RADIX_HEX;
                  base_in  = RADIX_HEX;
                  tail     = 1'b1;
                  tail_mul = 1'b1;
                  tail_acc = '0;
                  phase_in = PH_DIGITS;
               end
            end
            PH_DIGITS: begin
               tail     = 1'b1;
               tail_mul = 1'b1;
            end
            PH_OVER: tail = 1'b1;
            default: phase_in = PH_WS;
         endcase

         if (do_signed) begin
            // leading zero may open a prefix or select octal
            if ((b == RADIX_AUTO || b == RADIX_HEX) && q_item.is_zero) begin
               base_in  = b;
               cons_in  = cons_bump;
               phase_in = PH_ZERO;
            end else begin
               b       = (b == RADIX_AUTO) ? RADIX_DEC : b;
               base_in = b;
               if (q_item.digit >= b) begin
                  evt = EV_NO_DIGITS;
               end else begin
                  acc_in   = VALUE_BITS'(q_item.digit);
                  cons_in  = cons_bump;
                  phase_in = PH_DIGITS;
               end
            end
         end

         if (tail) begin
            prod = PROD_W'(tail_acc) * PROD_W'(b) + PROD_W'(q_item.digit);
            if (q_item.digit >= b) begin
               evt = EV_FINISH;
            end else begin
               if (tail_mul) begin
                  if (prod[PROD_W-1:VALUE_BITS] != '0)
                     phase_in = PH_OVER;
                  else
                     acc_in = prod[VALUE_BITS-1:0];
               end
               cons_in = cons_bump;
            end
         end

         if (evt != EV_NONE) begin
            phase_in = PH_WS;
            neg_in   = 1'b0;
            base_in  = '0;
            acc_in   = '0;
            cons_in  = '0;
         end
      end
   end

   // result for the current event
   always_comb begin
      logic [63:0] y;
      logic [63:0] fval;
      logic        n;
      logic        over;
      logic [31:0] cons_w;
      ais_status_type fst;

      over   = phase_ff == PH_OVER;
      y      = over ? cfg.limit
                    : ((phase_ff == PH_ZERO) ? 64'd0 : 64'(acc_ff));
      n      = (over && cfg.limit[0]) ? 1'b0 : neg_ff;
      fst    = over ? ST_RANGE : ST_OK;
      fval   = n ? (64'd0 - y) : y;
      if (y >= cfg.limit) begin
         if (!cfg.limit[0] && !n) begin
            fval = cfg.limit - 64'd1;
            fst  = ST_RANGE;
         end else if (y > cfg.limit) begin
            fval = cfg.limit;
            fst  = ST_RANGE;
         end
      end
      cons_w = 32'(cons_ff);

      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      value_in     = value_ff;
      count_in     = count_ff;
      status_in    = status_ff;
      if (fire && evt != EV_NONE) begin
         rsp_valid_in = 1'b1;
         value_in     = '0;
         count_in     = '0;
         case (evt)
            EV_FINISH: begin
               value_in  = fval & VALUE_MASK;
               count_in  = (cons_w > 32'h0000_ffff) ? 16'hffff : cons_w[15:0];
               status_in = fst;
            end
            EV_BARE_PREFIX: begin
               if (cfg.prefix_ok)
                  count_in = (cons_w - 32'd1 > 32'h0000_ffff) ? 16'hffff
                                                              : 16'(cons_w - 32'd1);
               status_in = ST_BARE_PREFIX;
            end
            EV_NO_DIGITS: status_in = ST_NO_DIGITS;
            EV_BAD_RADIX: status_in = ST_BAD_RADIX;
            default:      status_in = ST_OK;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WS;
         neg_ff       <= 1'b0;
         base_ff      <= '0;
         acc_ff       <= '0;
         cons_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         neg_ff       <= neg_in;
         base_ff      <= base_in;
         acc_ff       <= acc_in;
         cons_ff      <= cons_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      count_ff  <= count_in;
      status_ff <= status_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.value      = value_ff;
   assign rsp_ch.used_count = count_ff;
   assign rsp_ch.status     = status_ff;

endmodule

// ----- rtl/ascii_integer_scanner.sv -----
`timescale 1ns / 1ps
// Throughput: one character item per cycle while the result register is free or being
// accepted, set by the combinational multiply-add and overflow check in the back end; the
// two-entry queue lets either side stall. A taken terminator is written into the queue,
// then the back end loads its result into the output register, where it can be accepted.
// Reset (synchronous, active high) empties the queue and output register, starts a
// new scan and sets radix 10, prefix_ok 0 and limit all ones.
module ascii_integer_scanner
   import ais_pkg::*;
#(
   parameter int VALUE_BITS = 64,
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   ais_req_if.sink     req_ch,
   ais_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [63:0] csr_wdata
);

   ais_cfg_type               cfg_ff, cfg_in;
   logic                      push;
   ais_class_type             push_item;
   logic                      q_pop;
   logic                      q_valid;
   ais_class_type             q_item;
   logic                      q_full;
   logic [QUEUE_LVL_W-1:0]    q_level;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_RADIX:     cfg_in.radix     = csr_wdata[5:0];
            CSR_PREFIX_OK: cfg_in.prefix_ok = csr_wdata[0];
            CSR_LIMIT:     cfg_in.limit     = csr_wdata;
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.radix     <= RADIX_DEC;
         cfg_ff.prefix_ok <= 1'b0;
         cfg_ff.limit     <= {64{1'b1}};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   ais_front u_front (
      .req_ch    (req_ch),
      .q_full    (q_full),
      .push      (push),
      .push_item (push_item)
   );

   ais_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_item  (q_item),
      .full       (q_full),
      .level      (q_level)
   );

   ais_back #(
      .VALUE_BITS (VALUE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg_ff),
      .q_valid (q_valid),
      .q_item  (q_item),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

   // reset leaves nothing in flight
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_ch.valid && q_level == '0))
      else $error("item in flight after reset");

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_level != '0)
      else $error("back end took an item from an empty queue");

   a_fail_value_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == ST_NO_DIGITS || rsp_ch.status == ST_BAD_RADIX
                        || rsp_ch.status == ST_BARE_PREFIX)) |-> rsp_ch.value == '0)
      else $error("failed scan returned a nonzero value");

   a_fail_count_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && (rsp_ch.status == ST_NO_DIGITS || rsp_ch.status == ST_BAD_RADIX))
      |-> rsp_ch.used_count == '0)
      else $error("unmatched scan reports consumed characters");

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for ascii_integer_scanner: streams characters, predicts each
// parse result and compares it. Depends on ais_pkg, ais_req_if/ais_rsp_if and the RTL.
module tb_top
   import ais_pkg::*;
;

   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [63:0]    value;
      logic [15:0]    used;
      ais_status_type status;
   } parse_result_type;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [63:0] csr_wdata;

   ais_req_if req_if();
   ais_rsp_if rsp_if();

   ascii_integer_scanner dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   ais_phase_type scan_phase;
   logic          scan_neg;
   logic [5:0]    scan_base;
   logic [63:0]   scan_acc;
   logic [15:0]   scan_used;
   logic [5:0]    cfg_radix;
   logic          cfg_prefix_ok;
   logic [63:0]   cfg_limit;

   parse_result_type parse_results_due[$];
   int            errors = 0;
   int            sent_items = 0;
   int            stall_cycles = 0;
   int            src_idle_pct = 20;
   int            snk_idle_pct = 71;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ---------------------------------------------------------------- predictor
   function automatic void clear_scan();
      scan_phase = PH_WS;
      scan_neg   = 1'b0;
      scan_base  = '0;
      scan_acc   = '0;
      scan_used  = '0;
   endfunction

   function automatic void post_result(logic [63:0] v, logic [15:0] n, ais_status_type st);
      parse_result_type r;
      r.value  = v;
      r.used   = n;
      r.status = st;
      parse_results_due.push_back(r);
      clear_scan();
   endfunction

   function automatic void bump_used();
      if (scan_used != 16'hFFFF) scan_used++;
   endfunction

   function automatic int unsigned digit_value(logic [7:0] ch, logic fin);
      if (fin) return 255;
      if (ch >= "0" && ch <= "9") return ch - "0";
      if (ch >= "a" && ch <= "z") return ch - "a" + 10;
      if (ch >= "A" && ch <= "Z") return ch - "A" + 10;
      return 255;
   endfunction

   function automatic void finish_scan();
      logic [63:0]    y;
      logic           neg;
      ais_status_type st;
      y   = scan_acc;
      neg = scan_neg;
      st  = ST_OK;
      if (scan_phase == PH_OVER) begin
         st = ST_RANGE;
         y  = cfg_limit;
         if (cfg_limit[0]) neg = 1'b0;
      end
      if (y >= cfg_limit) begin
         // even limit: positive side tops out one below it
         if (!cfg_limit[0] && !neg) begin
            post_result(cfg_limit - 64'd1, scan_used, ST_RANGE);
            return;
         end
         if (y > cfg_limit) begin
            post_result(cfg_limit, scan_used, ST_RANGE);
            return;
         end
      end
      if (neg) y = 64'd0 - y;
      post_result(y, scan_used, st);
   endfunction

   function automatic void scan_char(logic [7:0] ch, logic fin);
      int unsigned d;
      d = digit_value(ch, fin);
      if (scan_phase == PH_WS) begin
         if (cfg_radix > RADIX_MAX || cfg_radix == RADIX_ONE) begin
            post_result('0, '0, ST_BAD_RADIX);
            return;
         end
         scan_base = cfg_radix;
         if (!fin && (ch == " " || (ch >= 8'd9 && ch <= 8'd13))) begin
            bump_used();
            return;
         end
         scan_phase = PH_SIGNED;
         if (!fin && (ch == "+" || ch == "-")) begin
            scan_neg = (ch == "-");
            bump_used();
            return;
         end
      end
      if (scan_phase == PH_SIGNED) begin
         if ((scan_base == RADIX_AUTO || scan_base == RADIX_HEX) && !fin && ch == "0") begin
            bump_used();
            scan_phase = PH_ZERO;
            return;
         end
         if (scan_base == RADIX_AUTO) scan_base = RADIX_DEC;
         if (d >= scan_base) begin
            post_result('0, '0, ST_NO_DIGITS);
            return;
         end
         scan_acc = d;
         bump_used();
         scan_phase = PH_DIGITS;
         return;
      end
      if (scan_phase == PH_ZERO) begin
         if (!fin && (ch | 8'h20) == "x") begin
            bump_used();
            scan_phase = PH_PREFIX;
            return;
         end
         if (scan_base == RADIX_AUTO) scan_base = RADIX_OCT;
         scan_acc   = '0;
         scan_phase = PH_DIGITS;
      end else if (scan_phase == PH_PREFIX) begin
         if (d >= 16) begin
            // with prefix_ok the leading zero alone counts as the match
            post_result('0, cfg_prefix_ok ? scan_used - 16'd1 : 16'd0, ST_BARE_PREFIX);
            return;
         end
         scan_base  = RADIX_HEX;
         scan_acc   = '0;
         scan_phase = PH_DIGITS;
      end
      if (scan_base < 2 || scan_base > RADIX_MAX) scan_base = RADIX_DEC;
      if (d >= scan_base) begin
         finish_scan();
         return;
      end
      if (scan_phase == PH_DIGITS) begin
         if (scan_acc > (64'hFFFF_FFFF_FFFF_FFFF - d) / scan_base)
            scan_phase = PH_OVER;
         else
            scan_acc = scan_acc * scan_base + d;
      end
      bump_used();
   endfunction

   // ---------------------------------------------------------------- driving
   always @(negedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= snk_idle_pct);
   end

   task automatic send_char(input logic [7:0] ch, input logic fin);
      while ($urandom_range(99) < src_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.char_code <= ch;
      req_if.at_end    <= fin;
      do @(posedge clock); while (!(req_if.valid && req_if.ready));
      scan_char(ch, fin);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic send_string(input string s);
      foreach (s[i]) send_char(s[i], 1'b0);
      send_char(8'h00, 1'b1);
   endtask

   task automatic wait_idle();
      req_if.valid <= 1'b0;
      while (parse_results_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // writes all three registers back to back; upper junk bits must be ignored
   task automatic write_setting(input logic [5:0] rdx, input logic pfx, input logic [63:0] lim);
      logic [63:0] junk;
      wait_idle();
      junk = {$urandom, $urandom};
      csr_we    <= 1'b1;
      csr_index <= CSR_RADIX;
      csr_wdata <= {junk[63:6], rdx};
      @(negedge clock);
      csr_index <= CSR_PREFIX_OK;
      csr_wdata <= {junk[62:0], pfx};
      @(negedge clock);
      csr_index <= CSR_LIMIT;
      csr_wdata <= lim;
      @(negedge clock);
      csr_we <= 1'b0;
      cfg_radix     = rdx;
      cfg_prefix_ok = pfx;
      cfg_limit     = lim;
   endtask

   function automatic logic [7:0] pick_space();
      int unsigned v;
      v = $urandom_range(14, 9);
      return (v == 14) ? 8'h20 : 8'(v);
   endfunction

   function automatic logic [7:0] pick_digit(int unsigned base);
      int unsigned v;
      v = $urandom_range(base - 1, 0);
      if (v < 10) return "0" + 8'(v);
      return (($urandom_range(1) != 0) ? "a" : "A") + 8'(v - 10);
   endfunction

   // whitespace, sign, prefix, digits and a terminator, all optional or random
   task automatic send_random_number();
      int unsigned base;
      int unsigned n;
      base = cfg_radix;
      n = ($urandom_range(2) == 0) ? $urandom_range(3, 1) : 0;
      repeat (n) send_char(pick_space(), 1'b0);
      case ($urandom_range(2))
         1: send_char("+", 1'b0);
         2: send_char("-", 1'b0);
         default: ;
      endcase
      if ((base == RADIX_AUTO || base == RADIX_HEX) && $urandom_range(2) == 0) begin
         send_char("0", 1'b0);
         if ($urandom_range(1) != 0) begin
            send_char(($urandom_range(1) != 0) ? "x" : "X", 1'b0);
            base = RADIX_HEX;
         end else if (base == RADIX_AUTO) begin
            base = RADIX_OCT;
         end
      end
      if (base < 2 || base > RADIX_MAX) base = RADIX_DEC;
      n = ($urandom_range(6) == 0) ? $urandom_range(70, 10) : $urandom_range(8, 0);
      repeat (n) send_char(pick_digit(base), 1'b0);
      send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
   endtask

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      parse_result_type want;
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
         stall_cycles = 0;
      else
         stall_cycles++;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (parse_results_due.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected result: value %h count %0d status %0d",
                        rsp_if.value, rsp_if.used_count, rsp_if.status);
         end else begin
            want = parse_results_due.pop_front();
            if (rsp_if.value !== want.value || rsp_if.used_count !== want.used ||
                rsp_if.status !== want.status) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: exp value %h count %0d status %0d, got %h %0d %0d",
                           want.value, want.used, want.status,
                           rsp_if.value, rsp_if.used_count, rsp_if.status);
            end
         end
      end
   end

   // ---------------------------------------------------------------- tests
   task automatic test_directed();
      for (int c = 9; c <= 13; c++) send_char(8'(c), 1'b0);
      send_char(" ", 1'b0);
      send_char("-", 1'b0);
      send_char("4", 1'b0);
      send_char("2", 1'b0);
      send_char(8'hFF, 1'b0);          // terminator, not counted
      send_char(8'h00, 1'b0);          // no digits
      send_char("+", 1'b0);
      send_char("z", 1'b0);            // sign then non-digit
      write_setting(RADIX_HEX, 1'b1, '1);
      send_char("0", 1'b0);
      send_char("x", 1'b0);
      send_char("g", 1'b0);            // bare prefix, counted up to the zero
      send_string("0XfF");
      write_setting(RADIX_AUTO, 1'b0, '1);
      send_string("0x");               // bare prefix, no match
      send_string("017");              // auto octal
      write_setting(6'd37, 1'b0, '1);
      send_char("a", 1'b0);            // bad radix
   endtask

   task automatic test_limits();
      write_setting(RADIX_DEC, 1'b0, '1);
      send_string("99999999999999999999");
      write_setting(RADIX_DEC, 1'b0, 64'h8000_0000_0000_0000);
      send_string("-99999999999999999999");
      send_string("9223372036854775808");
      send_string("-9223372036854775808");
      write_setting(RADIX_DEC, 1'b0, 64'd1000);
      send_string("1000");
      send_string("-1001");
      write_setting(RADIX_DEC, 1'b0, 64'd999);
      send_string("999");
      send_string("-1000");
      write_setting(RADIX_DEC, 1'b1, 64'd0);
      send_string("5");
      send_string("-0");
      write_setting(RADIX_DEC, 1'b0, 64'd1);
      send_string("+1");
      write_setting(RADIX_MAX, 1'b0, '1);
      send_string("zzzzzzzzzzzzzz");
      write_setting(6'd2, 1'b0, '1);
      repeat (64) send_char("1", 1'b0);
      send_char(8'h00, 1'b1);          // exactly all ones
      repeat (65) send_char("1", 1'b0);
      send_char(8'h00, 1'b1);          // one bit too many
   endtask

   task automatic test_random(input int n_items);
      int          goal;
      int          stop_at;
      logic [5:0]  rdx;
      logic [63:0] lim;
      goal = sent_items + n_items;
      while (sent_items < goal) begin
         case ($urandom_range(9))
            0, 9: rdx = RADIX_AUTO;
            1: rdx = 6'd2;
            2: rdx = RADIX_OCT;
            3: rdx = RADIX_DEC;
            4: rdx = RADIX_HEX;
            5: rdx = RADIX_MAX;
            6: rdx = 6'($urandom_range(35, 2));
            7: rdx = RADIX_ONE;
            default: rdx = 6'($urandom_range(63, 37));
         endcase
         case ($urandom_range(7))
            0, 1: lim = '1;
            2: lim = 64'h8000_0000_0000_0000;
            3: lim = 64'h7FFF_FFFF_FFFF_FFFF;
            4: lim = 64'd0;
            5: lim = 64'd1;
            6: lim = 64'($urandom_range(1000));
            default: lim = {$urandom, $urandom};
         endcase
         write_setting(rdx, 1'($urandom_range(1)), lim);
         stop_at = sent_items + $urandom_range(80, 40);
         while (sent_items < stop_at && sent_items < goal) begin
            if ($urandom_range(99) < 15)
               repeat ($urandom_range(4, 1))
                  send_char(8'($urandom_range(255)), $urandom_range(7) == 0);
            else
               send_random_number();
         end
         send_char(8'h00, 1'b1);       // close any open scan before the next setting
      end
   endtask

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.char_code = '0;
      req_if.at_end    = 1'b0;
      rsp_if.ready     = 1'b0;
      csr_we           = 1'b0;
      csr_index        = CSR_RADIX;
      csr_wdata        = '0;
      cfg_radix        = RADIX_DEC;
      cfg_prefix_ok    = 1'b0;
      cfg_limit        = '1;
      clear_scan();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_directed();
      test_limits();
      test_random(150);
      src_idle_pct = 71;
      snk_idle_pct = 20;
      test_random(150);
      src_idle_pct = 0;
      snk_idle_pct = 0;
      test_random(150);

      wait_idle();
      repeat (8) @(negedge clock);
      if (errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
